// File: design/dsa_pkg.sv
package dsa_pkg;

    // Field widths fixed by the descriptor handle format
    localparam int SLOT_COUNT_W  = 11;
    localparam int SLOT_STRIDE_W = 13;
    localparam int ADDR_W        = 64;
    localparam int HANDLE_W      = 10;
    localparam int INDEX_W       = 32;
    localparam int OFFSET_W      = SLOT_COUNT_W + SLOT_STRIDE_W;
    localparam int CFG_INDEX_W   = 3;
    localparam int DIV_CNT_W     = 6;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_STRIDE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CPU_BASE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GPU_BASE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHADER_VISIBLE = 3'd4;

    // Configuration reset values
    localparam logic [SLOT_COUNT_W-1:0]  SLOT_COUNT_RST  = 11'd1024;
    localparam logic [SLOT_STRIDE_W-1:0] SLOT_STRIDE_RST = 13'd32;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_RESET = 2'd2,
        REQ_FIND  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_INVALID  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_CPU,
        ST_GPU,
        ST_SUB,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        req_type_t             req_type;
        logic [HANDLE_W-1:0]   handle_slot;
        logic                  handle_valid;
        logic [ADDR_W-1:0]     query_address;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [INDEX_W-1:0]    slot_index;
        logic [ADDR_W-1:0]     cpu_address;
        logic [ADDR_W-1:0]     gpu_address;
    } rsp_t;

endpackage

// File: design/descriptor_slot_allocator.sv
// Descriptor slot allocator.
// Requests enter on req (req_valid / req_stall) and each one gives exactly one
// transaction on rsp (rsp_valid / rsp_stall). Registers are written on the cfg
// channel (cfg_valid / cfg_ready, always ready), by the user only while no request
// is in flight; the block does not enforce it. Allocate reuses the oldest freed slot
// from an internal free queue, else the next never-used slot, else answers heap full.
// Free pushes a valid handle. Reset empties the queue and restarts the fresh counter;
// find returns (query_address - cpu_base) / slot_stride truncated to 32 bits.
// One request is worked at a time; req_stall is high until its result has been
// moved into the output register. With no stall the next request is taken in
// the cycle in which rsp_valid rises. Allocate goes through ST_LOAD (free queue
// only), ST_MUL, ST_CPU and, with shader visibility, ST_GPU; find goes through
// ST_SUB and ST_DIV (skipped when slot_stride is 0); all end in ST_OUT.
// Find is set by the restoring divider, one quotient bit per cycle over the
// 64-bit difference; every address sum goes through one shared 64-bit adder.
// A new request is taken while the last result still waits on rsp_stall; its
// own result then waits until the output register empties.
// Reset clears the queue pointers, the fresh counter and the registers to
// their defaults; queue contents are not cleared and need no clearing pass.
module descriptor_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  dsa_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output dsa_pkg::rsp_t                     rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dsa_pkg::ADDR_W-1:0]        cfg_data
);
    import dsa_pkg::*;

    localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FW = $clog2(MAX_SLOTS + 1);

    // Advance a queue pointer round the ring
    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(MAX_SLOTS - 1))
            r = '0;
        else
            r = p + PW'(1);
        return r;
    endfunction

    // Configuration
    logic [SLOT_COUNT_W-1:0]  slot_count_reg;
    logic [SLOT_STRIDE_W-1:0] slot_stride_reg;
    logic [ADDR_W-1:0]        cpu_base_reg;
    logic [ADDR_W-1:0]        gpu_base_reg;
    logic                     shader_visible_reg;

    // Queue and allocator state
    logic [HANDLE_W-1:0] free_mem [MAX_SLOTS];
    logic [HANDLE_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       fresh_reg, fresh_next;

    // Sequencer and working registers
    state_t                   state_reg, state_next;
    rsp_t                     res_reg, res_next;
    logic [SLOT_COUNT_W-1:0]  idx_reg, idx_next;
    logic [OFFSET_W-1:0]      off_reg, off_next;
    logic [ADDR_W-1:0]        query_reg, query_next;
    logic [ADDR_W-1:0]        dvd_reg, dvd_next;
    logic [SLOT_STRIDE_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;

    // Output register
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;
    logic rsp_load;

    // Shared adder
    logic [ADDR_W-1:0] add_a, add_b, add_sum;
    logic              add_sub;

    // Divider step
    logic [SLOT_STRIDE_W:0] trial;
    logic [SLOT_STRIDE_W:0] trial_diff;
    logic                   trial_ge;

    logic          req_fire;
    logic          fresh_ok;
    logic [31:0]   fresh_wide;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign add_sum = add_a + (add_b ^ {ADDR_W{add_sub}}) + ADDR_W'(add_sub);

    assign trial      = {rem_reg, dvd_reg[ADDR_W-1]};
    assign trial_diff = trial - {1'b0, slot_stride_reg};
    assign trial_ge   = (trial >= {1'b0, slot_stride_reg});

    assign fresh_wide = 32'(fresh_reg);
    assign fresh_ok   = (fresh_wide < 32'(slot_count_reg)) && (fresh_wide < 32'(MAX_SLOTS));

    // Next state, datapath control and queue updates
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        fresh_next     = fresh_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        query_next     = query_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        mem_we         = 1'b0;
        rsp_load       = 1'b0;
        add_a          = cpu_base_reg;
        add_b          = ADDR_W'(off_reg);
        add_sub        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    res_next   = '0;
                    query_next = req.query_address;
                    unique case (req.req_type)
                        REQ_ALLOC:
                        begin
                            if (fill_reg != '0)
                            begin
                                head_next  = ring_next(head_reg);
                                fill_next  = fill_reg - FW'(1);
                                state_next = ST_LOAD;
                            end
                            else if (fresh_ok)
                            begin
                                idx_next   = fresh_wide[SLOT_COUNT_W-1:0];
                                fresh_next = fresh_reg + FW'(1);
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                res_next.status = STATUS_FULL;
                                state_next      = ST_OUT;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (!req.handle_valid)
                                res_next.status = STATUS_INVALID;
                            else if (fill_reg == FW'(MAX_SLOTS))
                                res_next.status = STATUS_OVERFLOW;
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = ring_next(tail_reg);
                                fill_next = fill_reg + FW'(1);
                            end
                            state_next = ST_OUT;
                        end
                        REQ_RESET:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            fill_next  = '0;
                            fresh_next = '0;
                            state_next = ST_OUT;
                        end
                        REQ_FIND:
                        begin
                            state_next = ST_SUB;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                idx_next   = {1'b0, rd_data_reg};
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                off_next   = idx_reg * slot_stride_reg;
                state_next = ST_CPU;
            end
            ST_CPU:
            begin
                add_a                = cpu_base_reg;
                add_b                = ADDR_W'(off_reg);
                res_next.cpu_address = add_sum;
                res_next.slot_index  = INDEX_W'(idx_reg);
                state_next           = shader_visible_reg ? ST_GPU : ST_OUT;
            end
            ST_GPU:
            begin
                add_a                = gpu_base_reg;
                add_b                = ADDR_W'(off_reg);
                res_next.gpu_address = add_sum;
                state_next           = ST_OUT;
            end
            ST_SUB:
            begin
                add_a    = query_reg;
                add_b    = cpu_base_reg;
                add_sub  = 1'b1;
                dvd_next = add_sum;
                rem_next = '0;
                cnt_next = '1;
                if (slot_stride_reg == '0)
                begin
                    res_next.slot_index = '1;
                    state_next          = ST_OUT;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // one restoring step: shift in a dividend bit, subtract if it fits
                rem_next = trial_ge ? trial_diff[SLOT_STRIDE_W-1:0] : trial[SLOT_STRIDE_W-1:0];
                dvd_next = {dvd_reg[ADDR_W-2:0], trial_ge};
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    res_next.slot_index = dvd_next[INDEX_W-1:0];
                    state_next          = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Queue pointers, fresh counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg     <= SLOT_COUNT_RST;
            slot_stride_reg    <= SLOT_STRIDE_RST;
            cpu_base_reg       <= '0;
            gpu_base_reg       <= '0;
            shader_visible_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[SLOT_COUNT_W-1:0];
                CFG_SLOT_STRIDE:    slot_stride_reg    <= cfg_data[SLOT_STRIDE_W-1:0];
                CFG_CPU_BASE:       cpu_base_reg       <= cfg_data;
                CFG_GPU_BASE:       gpu_base_reg       <= cfg_data;
                CFG_SHADER_VISIBLE: shader_visible_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        idx_reg   <= idx_next;
        off_reg   <= off_next;
        query_reg <= query_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        if (rsp_load)
            rsp_reg <= res_reg;
    end

    // Free queue storage: push at the tail, read the head every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            free_mem[tail_reg] <= req.handle_slot;
        rd_data_reg <= free_mem[head_reg];
    end

`ifndef NO_ASSERTIONS
    // Queue fill never exceeds its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_SLOTS))
        else $error("free queue fill above depth");

    // An empty queue has its pointers together
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with pointers apart");

    // Divider remainder stays below the stride
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < slot_stride_reg))
        else $error("divider remainder not below stride");

    // Allocate from the queue pops exactly one entry
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type == REQ_ALLOC && fill_reg != '0)
            |=> (fill_reg == $past(fill_reg) - FW'(1)))
        else $error("allocate did not pop the free queue");
`endif

endmodule

// File: verif/slot_allocator_checker.sv
`timescale 1ns / 100ps

module slot_allocator_checker #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  dsa_pkg::req_t                   req,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  dsa_pkg::rsp_t                   rsp,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dsa_pkg::ADDR_W-1:0]      cfg_data,
    output int                              mismatch_count,
    output int                              answers_owed
);
    import dsa_pkg::*;

    localparam int PTR_W = $clog2(MAX_SLOTS);

    // Shadow register file
    logic [SLOT_COUNT_W-1:0]  slot_count;
    logic [SLOT_STRIDE_W-1:0] slot_stride;
    logic [ADDR_W-1:0]        cpu_base;
    logic [ADDR_W-1:0]        gpu_base;
    logic                     shader_visible;

    // Shadow free-slot queue and fresh counter
    logic [HANDLE_W-1:0] freed_slots [MAX_SLOTS];
    logic [PTR_W-1:0]    free_head;
    logic [PTR_W-1:0]    free_tail;
    logic [PTR_W:0]      free_fill;
    logic [PTR_W:0]      next_fresh;

    rsp_t owed_answers[$];
    rsp_t oldest;
    int   answers_seen;

    function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
        return (p == PTR_W'(MAX_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void clear_slots();
        free_head  = '0;
        free_tail  = '0;
        free_fill  = '0;
        next_fresh = '0;
    endfunction

    function automatic void write_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [ADDR_W-1:0] data);
        case (idx)
            CFG_SLOT_COUNT:     slot_count     = data[SLOT_COUNT_W-1:0];
            CFG_SLOT_STRIDE:    slot_stride    = data[SLOT_STRIDE_W-1:0];
            CFG_CPU_BASE:       cpu_base       = data;
            CFG_GPU_BASE:       gpu_base       = data;
            CFG_SHADER_VISIBLE: shader_visible = data[0];
            default:            ;
        endcase
    endfunction

    // Work out the answer to one request and advance the shadow state
    function automatic rsp_t predict_answer(req_t r);
        rsp_t                a;
        int                  limit;
        logic                got;
        logic [HANDLE_W-1:0] idx;
        logic [ADDR_W-1:0]   offset;
        logic [ADDR_W-1:0]   diff;
        a     = '0;
        got   = 1'b0;
        idx   = '0;
        limit = (int'(slot_count) < MAX_SLOTS) ? int'(slot_count) : MAX_SLOTS;
        case (r.req_type)
            REQ_ALLOC:
            begin
                // reuse the oldest freed slot first, then a fresh one
                if (free_fill != 0)
                begin
                    idx       = freed_slots[free_head];
                    free_head = ring_step(free_head);
                    free_fill = free_fill - 1'b1;
                    got       = 1'b1;
                end
                else if (int'(next_fresh) < limit)
                begin
                    idx        = HANDLE_W'(next_fresh);
                    next_fresh = next_fresh + 1'b1;
                    got        = 1'b1;
                end
                if (got)
                begin
                    offset        = ADDR_W'(idx) * ADDR_W'(slot_stride);
                    a.slot_index  = INDEX_W'(idx);
                    a.cpu_address = cpu_base + offset;
                    a.gpu_address = shader_visible ? gpu_base + offset : '0;
                end
                else
                begin
                    a.status = STATUS_FULL;
                end
            end
            REQ_FREE:
            begin
                // drop invalid handles and pushes into a full queue
                if (!r.handle_valid)
                begin
                    a.status = STATUS_INVALID;
                end
                else if (int'(free_fill) >= MAX_SLOTS)
                begin
                    a.status = STATUS_OVERFLOW;
                end
                else
                begin
                    freed_slots[free_tail] = r.handle_slot;
                    free_tail              = ring_step(free_tail);
                    free_fill              = free_fill + 1'b1;
                end
            end
            REQ_RESET:
            begin
                clear_slots();
            end
            default:
            begin
                // find: wrapped difference over stride, zero stride gives all ones
                diff = r.query_address - cpu_base;
                if (slot_stride == 0)
                    a.slot_index = '1;
                else
                    a.slot_index = INDEX_W'(diff / ADDR_W'(slot_stride));
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string field, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        $display("[%0t] answer %0d: %s got %h, want %h", $realtime,
                 answers_seen, field, got, want);
        mismatch_count++;
    endtask

    // Track configuration, predict on each request, compare on each answer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count     <= SLOT_COUNT_RST;
            slot_stride    <= SLOT_STRIDE_RST;
            cpu_base       <= '0;
            gpu_base       <= '0;
            shader_visible <= 1'b0;
            free_head      <= '0;
            free_tail      <= '0;
            free_fill      <= '0;
            next_fresh     <= '0;
            answers_seen   <= 0;
            answers_owed   <= 0;
            owed_answers.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                owed_answers.push_back(predict_answer(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_answers.size() == 0)
                begin
                    report_mismatch("transaction with no request waiting",
                                    ADDR_W'(rsp.slot_index), '0);
                end
                else
                begin
                    oldest = owed_answers.pop_front();
                    if (rsp.status !== oldest.status)
                        report_mismatch("status", ADDR_W'(rsp.status),
                                        ADDR_W'(oldest.status));
                    if (rsp.slot_index !== oldest.slot_index)
                        report_mismatch("slot_index", ADDR_W'(rsp.slot_index),
                                        ADDR_W'(oldest.slot_index));
                    if (rsp.cpu_address !== oldest.cpu_address)
                        report_mismatch("cpu_address", rsp.cpu_address,
                                        oldest.cpu_address);
                    if (rsp.gpu_address !== oldest.gpu_address)
                        report_mismatch("gpu_address", rsp.gpu_address,
                                        oldest.gpu_address);
                end
                answers_seen++;
            end
            answers_owed <= owed_answers.size();
        end
    end

endmodule

// File: verif/tb_descriptor_slot_allocator.sv
`timescale 1ns / 100ps

module tb_descriptor_slot_allocator;

    import dsa_pkg::*;

    localparam int MAX_SLOTS   = 1024;
    localparam int STUCK_LIMIT = 2000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_t                   req       = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SLOT_COUNT;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    int   mismatch_count;
    int   answers_owed;
    int   stuck_cycles = 0;
    int   stall_left   = 0;
    logic no_idle      = 1'b0;

    // Current settings, kept only to aim find addresses at real slots
    logic [SLOT_STRIDE_W-1:0] cur_stride = SLOT_STRIDE_RST;
    logic [ADDR_W-1:0]        cur_base   = '0;

    descriptor_slot_allocator #(
        .MAX_SLOTS (MAX_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slot_allocator_checker #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .answers_owed   (answers_owed)
    );

    always #2 clk = ~clk;

    // Receiver: stall in random bursts with random open stretches
    always @(posedge clk)
    begin
        if (no_idle)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (rsp_stall)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 30);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end
    end

    // Abort when no transaction moves on any channel for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t make_req(req_type_t kind, logic [HANDLE_W-1:0] slot,
                                      logic valid, logic [ADDR_W-1:0] addr);
        req_t r;
        r.req_type      = kind;
        r.handle_slot   = slot;
        r.handle_valid  = valid;
        r.query_address = addr;
        return r;
    endfunction

    // Mostly allocate/free traffic, finds aimed near slot addresses, rare resets
    function automatic req_t random_request();
        req_t r;
        int   pick;
        int   k;
        int   off;
        pick  = $urandom_range(0, 99);
        r     = make_req(REQ_ALLOC, HANDLE_W'($urandom), $urandom_range(0, 9) != 0,
                         rand64());
        if ($urandom_range(0, 1) == 0)
            r.handle_slot = HANDLE_W'($urandom_range(0, 15));
        if (pick < 45)
        begin
            r.req_type = REQ_ALLOC;
        end
        else if (pick < 75)
        begin
            r.req_type = REQ_FREE;
        end
        else if (pick < 94)
        begin
            r.req_type = REQ_FIND;
            if ($urandom_range(0, 3) != 0)
            begin
                k   = $urandom_range(0, 1100);
                off = (cur_stride == 0) ? 0 : $urandom_range(0, cur_stride - 1);
                r.query_address = cur_base + ADDR_W'(k) * ADDR_W'(cur_stride) +
                                  ADDR_W'(off);
            end
        end
        else
        begin
            r.req_type = REQ_RESET;
        end
        return r;
    endfunction

    // Hold the request until the block takes it; valid stays up afterwards
    task automatic send_request(req_t r);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    // Stop sending and wait for every owed answer
    task automatic drain_answers();
        req_valid <= 1'b0;
        do @(posedge clk); while (answers_owed != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic put_register(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all registers; unused upper data bits carry noise
    task automatic apply_settings(logic [SLOT_COUNT_W-1:0] count,
                                  logic [SLOT_STRIDE_W-1:0] stride,
                                  logic [ADDR_W-1:0] cbase,
                                  logic [ADDR_W-1:0] gbase,
                                  logic vis);
        logic [ADDR_W-1:0] noise;
        noise = rand64();
        put_register(CFG_SLOT_COUNT, {noise[ADDR_W-1:SLOT_COUNT_W], count});
        put_register(CFG_SLOT_STRIDE, {noise[ADDR_W-1:SLOT_STRIDE_W], stride});
        put_register(CFG_CPU_BASE, cbase);
        put_register(CFG_GPU_BASE, gbase);
        put_register(CFG_SHADER_VISIBLE, {noise[ADDR_W-1:1], vis});
        cfg_valid  <= 1'b0;
        cur_stride = stride;
        cur_base   = cbase;
    endtask

    initial
    begin
        int ph;
        int n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: fresh slots, reuse of a freed slot, invalid free, find
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_FREE, '1, 1'b1, '0));
        send_request(make_req(REQ_FREE, 10'd5, 1'b0, '1));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_FIND, '0, 1'b0, 64'h40));
        send_request(make_req(REQ_FIND, '0, 1'b0, '1));
        send_request(make_req(REQ_RESET, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));

        // Two slots, stride 4096, wrapping bases: heap full, dubious frees
        drain_answers();
        apply_settings(11'd2, 13'd4096, '1, 64'h8000_0000_0000_0000, 1'b1);
        send_request(make_req(REQ_RESET, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_FREE, '1, 1'b1, '0));
        send_request(make_req(REQ_FREE, '1, 1'b1, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_FIND, '0, 1'b0, '0));
        send_request(make_req(REQ_FIND, '0, 1'b0, 64'h2FFF));

        // Zero count and zero stride: only freed slots, base addresses, all-ones find
        drain_answers();
        apply_settings('0, '0, rand64(), rand64(), 1'b1);
        send_request(make_req(REQ_RESET, '0, 1'b0, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_FREE, 10'd7, 1'b1, '0));
        send_request(make_req(REQ_ALLOC, '0, 1'b0, '0));
        send_request(make_req(REQ_FIND, '0, 1'b0, rand64()));

        // Count beyond the table, largest stride: fill the free queue past its depth
        drain_answers();
        apply_settings('1, '1, rand64(), rand64(), 1'b1);
        send_request(make_req(REQ_RESET, '0, 1'b0, '0));
        for (n = 0; n < MAX_SLOTS + 3; n++)
            send_request(make_req(REQ_FREE, HANDLE_W'($urandom), 1'b1, rand64()));
        repeat (40) send_request(random_request());

        // Random traffic under several settings; the last phase runs without idling
        for (ph = 0; ph < 5; ph++)
        begin
            drain_answers();
            case (ph)
                0: apply_settings(SLOT_COUNT_W'($urandom_range(1, 8)),
                                  SLOT_STRIDE_W'($urandom_range(1, 4096)),
                                  rand64(), rand64(), 1'b1);
                1: apply_settings(11'd1024, 13'd1, '0, '1, 1'b0);
                2: apply_settings(SLOT_COUNT_W'($urandom), SLOT_STRIDE_W'($urandom),
                                  rand64(), rand64(), 1'($urandom));
                3: apply_settings(11'd1, 13'd4096, '1, '0, 1'b1);
                default: apply_settings(SLOT_COUNT_W'($urandom_range(1, 64)),
                                        SLOT_STRIDE_W'($urandom_range(1, 4096)),
                                        rand64(), rand64(), 1'b1);
            endcase
            no_idle <= (ph == 4);
            repeat (100) send_request(random_request());
        end

        drain_answers();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && answers_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
design/dsa_pkg.sv
design/descriptor_slot_allocator.sv
verif/slot_allocator_checker.sv
verif/tb_descriptor_slot_allocator.sv
